### rtl/rau_pkg.sv
// package: widths, operation codes, compare codes and sequencer states of the rational unit
package rau_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 16;
   localparam int EFF_WIDTH_MAX = 31;
   localparam int KIND_W = 3;
   localparam int ORDER_W = 2;
   localparam int RESULT_NUM_W = 33;
   localparam int RESULT_DEN_W = 31;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_CMP = 3'd4
   } rau_kind_type;

   localparam logic [ORDER_W-1:0] ORDER_LESS = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_EQUAL = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMBINE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } rau_state_type;

endpackage

### rtl/rau_mul.sv
// shared signed multiplier with registered product
module rau_mul #(
   parameter int IN_W = 17
) (
   input  logic                   clock,
   input  logic signed [IN_W-1:0] op_a,
   input  logic signed [IN_W-1:0] op_b,
   output logic signed [2*IN_W-1:0] product
);
   logic signed [2*IN_W-1:0] prod_ff;
   logic signed [2*IN_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
endmodule

### rtl/rau_gcd.sv
// iterative binary gcd, one subtract or shift per cycle
module rau_gcd #(
   parameter int MW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] arg_u,
   input  logic [MW-1:0] arg_v,
   output logic          done,
   output logic [MW-1:0] gcd
);
   localparam int ShW = $clog2(MW);

   logic [MW-1:0]  u_ff, u_in;
   logic [MW-1:0]  v_ff, v_in;
   logic [ShW-1:0] shift_ff, shift_in;
   logic [MW-1:0]  gcd_ff, gcd_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      shift_in = shift_ff;
      gcd_in = gcd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         u_in = arg_u;
         v_in = arg_v;
         shift_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         priority if (u_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            gcd_in = v_ff << shift_ff;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            shift_in = shift_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      shift_ff <= shift_in;
      gcd_ff <= gcd_in;
   end

   assign done = done_ff;
   assign gcd = gcd_ff;
endmodule

### rtl/rau_div.sv
// restoring divider, one quotient bit per cycle
module rau_div #(
   parameter int MW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] dividend,
   input  logic [MW-1:0] divisor,
   output logic          done,
   output logic [MW-1:0] quotient
);
   localparam int CntW = $clog2(MW);

   logic [MW:0]     rem_ff, rem_in;
   logic [MW-1:0]   quo_ff, quo_in;
   logic [MW-1:0]   div_ff, div_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [MW:0]     shifted;

   assign shifted = {rem_ff[MW-1:0], quo_ff[MW-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = shifted - {1'b0, div_ff};
            quo_in = {quo_ff[MW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[MW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(MW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

### rtl/rational_arithmetic_unit.sv
// top level: sequencer of the rational unit around shared multiplier, gcd and divider
//
// request channel (req_): kind and two fractions, taken when req_valid is high and
// req_stall low; req_stall is high while a transaction is in work.
// response channel (rsp_): one transaction per request, held in an output register
// until taken (rsp_valid high, rsp_stall low); a new request is accepted while a
// finished response still waits, the next one then waits for the register to free.
// add, subtract, multiply and divide run three multiplies on one shared multiplier,
// a binary gcd of one subtract or shift per cycle (a shift follows every subtract),
// then two restoring divisions of MW bits, MW = 2*min(OPERAND_WIDTH,31)+1.
// one transaction is in work at a time; the next request can be taken from the cycle
// after the response register is loaded.
// reset (synchronous, active high) returns to idle and drops rsp_valid.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [rau_pkg::KIND_W-1:0]             req_kind,
   input  logic signed [OPERAND_WIDTH-1:0]        req_first_num,
   input  logic signed [OPERAND_WIDTH-1:0]        req_first_den,
   input  logic signed [OPERAND_WIDTH-1:0]        req_second_num,
   input  logic signed [OPERAND_WIDTH-1:0]        req_second_den,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rau_pkg::RESULT_NUM_W-1:0] rsp_result_num,
   output logic [rau_pkg::RESULT_DEN_W-1:0]       rsp_result_den,
   output logic [rau_pkg::ORDER_W-1:0]            rsp_order,
   output logic                                   rsp_error
);
   import rau_pkg::*;

   localparam int EW = (OPERAND_WIDTH > EFF_WIDTH_MAX) ? EFF_WIDTH_MAX : OPERAND_WIDTH;
   localparam int OW = EW + 1;
   localparam int PW = 2 * OW;
   localparam int MW = PW - 1;

   rau_state_type           state_ff, state_in;
   rau_kind_type            kind_ff, kind_in;
   logic signed [OW-1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic signed [PW-1:0]    p0_ff, p0_in, p1_ff, p1_in;
   logic                    err_ff, err_in;
   logic [ORDER_W-1:0]      order_ff, order_in;
   logic                    sign_ff, sign_in;
   logic [MW-1:0]           mag_ff, mag_in, den_ff, den_in, qn_ff, qn_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic [RESULT_DEN_W-1:0] rsp_den_ff, rsp_den_in;
   logic [ORDER_W-1:0]      rsp_order_ff, rsp_order_in;
   logic                    rsp_error_ff, rsp_error_in;

   logic signed [OW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_prod;
   logic                    gcd_start, gcd_done;
   logic [MW-1:0]           gcd_u, gcd_v, gcd_value;
   logic                    div_start, div_done;
   logic [MW-1:0]           div_dividend, div_quotient;

   logic signed [OW-1:0]    ext_a, ext_b, ext_c, ext_d;
   logic                    bad_req;
   logic signed [PW-1:0]    num_c, den_c, num_fix, den_fix, num_abs, signed_q;

   rau_mul #(.IN_W(OW)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_prod)
   );

   rau_gcd #(.MW(MW)) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .arg_u (gcd_u),
      .arg_v (gcd_v),
      .done  (gcd_done),
      .gcd   (gcd_value)
   );

   rau_div #(.MW(MW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_value),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sign extension at the effective operand width
   assign ext_a = OW'(signed'(req_first_num[EW-1:0]));
   assign ext_b = OW'(signed'(req_first_den[EW-1:0]));
   assign ext_c = OW'(signed'(req_second_num[EW-1:0]));
   assign ext_d = OW'(signed'(req_second_den[EW-1:0]));

   assign bad_req = (req_kind > KIND_CMP) || (ext_b == '0) || (ext_d == '0) ||
                    ((req_kind == KIND_DIV) && (ext_c == '0));

   // cross products combined into an unreduced fraction
   always_comb begin
      unique case (kind_ff)
         KIND_ADD: begin
            num_c = p0_ff + p1_ff;
            den_c = mul_prod;
         end
         KIND_SUB: begin
            num_c = p0_ff - p1_ff;
            den_c = mul_prod;
         end
         default: begin
            num_c = p0_ff;
            den_c = p1_ff;
         end
      endcase
      num_fix = (den_c < 0) ? -num_c : num_c;
      den_fix = (den_c < 0) ? -den_c : den_c;
      num_abs = (num_fix < 0) ? -num_fix : num_fix;
   end

   assign gcd_u = MW'(num_abs);
   assign gcd_v = MW'(den_fix);
   assign signed_q = sign_ff ? -signed'({1'b0, qn_ff}) : signed'({1'b0, qn_ff});

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      err_in = err_ff;
      order_in = order_ff;
      sign_in = sign_ff;
      mag_in = mag_ff;
      den_in = den_ff;
      qn_in = qn_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in = rsp_num_ff;
      rsp_den_in = rsp_den_ff;
      rsp_order_in = rsp_order_ff;
      rsp_error_in = rsp_error_ff;
      mul_a = a_ff;
      mul_b = d_ff;
      gcd_start = 1'b0;
      div_start = 1'b0;
      div_dividend = mag_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = rau_kind_type'(req_kind);
               a_in = (ext_b < 0) ? -ext_a : ext_a;
               b_in = (ext_b < 0) ? -ext_b : ext_b;
               c_in = (ext_d < 0) ? -ext_c : ext_c;
               d_in = (ext_d < 0) ? -ext_d : ext_d;
               err_in = bad_req;
               order_in = ORDER_LESS;
               state_in = bad_req ? ST_FINISH : ST_MUL0;
            end
         end
         ST_MUL0: begin
            mul_a = a_ff;
            mul_b = (kind_ff == KIND_MUL) ? c_ff : d_ff;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p0_in = mul_prod;
            mul_a = b_ff;
            mul_b = (kind_ff == KIND_MUL) ? d_ff : c_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p1_in = mul_prod;
            mul_a = b_ff;
            mul_b = d_ff;
            state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            if (kind_ff == KIND_CMP) begin
               priority if (p0_ff < p1_ff) begin
                  order_in = ORDER_LESS;
               end else if (p0_ff == p1_ff) begin
                  order_in = ORDER_EQUAL;
               end else begin
                  order_in = ORDER_GREATER;
               end
               state_in = ST_FINISH;
            end else begin
               sign_in = num_fix < 0;
               mag_in = gcd_u;
               den_in = gcd_v;
               gcd_start = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (gcd_done) begin
               div_start = 1'b1;
               div_dividend = mag_ff;
               state_in = ST_DIV_NUM;
            end
         end
         ST_DIV_NUM: begin
            if (div_done) begin
               qn_in = div_quotient;
               div_start = 1'b1;
               div_dividend = den_ff;
               state_in = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               priority if (err_ff) begin
                  rsp_num_in = '0;
                  rsp_den_in = '0;
                  rsp_order_in = ORDER_LESS;
                  rsp_error_in = 1'b1;
               end else if (kind_ff == KIND_CMP) begin
                  rsp_num_in = '0;
                  rsp_den_in = '0;
                  rsp_order_in = order_ff;
                  rsp_error_in = 1'b0;
               end else begin
                  rsp_num_in = RESULT_NUM_W'(signed_q);
                  rsp_den_in = RESULT_DEN_W'(div_quotient);
                  rsp_order_in = ORDER_LESS;
                  rsp_error_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      err_ff <= err_in;
      order_ff <= order_in;
      sign_ff <= sign_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      qn_ff <= qn_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_order_ff <= rsp_order_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_num = rsp_num_ff;
   assign rsp_result_den = rsp_den_ff;
   assign rsp_order = rsp_order_ff;
   assign rsp_error = rsp_error_ff;
endmodule

### dv/rational_arithmetic_unit_tb.sv
// testbench: self-checking random and directed test of the rational arithmetic unit
module rational_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rau_pkg::*;

   localparam int OPW = OPERAND_WIDTH_DEFAULT;
   localparam int PHASE_ITEMS = 460;
   localparam int DRAIN_CYCLES = 200;
   localparam int QUIET_LIMIT = 4000;
   localparam logic [KIND_W-1:0] KIND_LAST_CODE = '1;

   typedef logic signed [OPW-1:0] operand_type;

   localparam operand_type OP_MIN = {1'b1, {(OPW-1){1'b0}}};
   localparam operand_type OP_MAX = {1'b0, {(OPW-1){1'b1}}};

   localparam int unsigned SEND_IDLE_PCT[4] = '{0, 60, 0, 10};
   localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 60, 10};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      operand_type       first_num;
      operand_type       first_den;
      operand_type       second_num;
      operand_type       second_den;
   } fraction_pair_type;

   typedef struct packed {
      logic signed [RESULT_NUM_W-1:0] num;
      logic [RESULT_DEN_W-1:0]        den;
      logic [ORDER_W-1:0]             order;
      logic                           error;
   } rational_result_type;

   typedef struct {
      fraction_pair_type op;
      int unsigned       mode;
      bit                drain;
   } pending_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   operand_type req_first_num = '0;
   operand_type req_first_den = '0;
   operand_type req_second_num = '0;
   operand_type req_second_den = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [RESULT_NUM_W-1:0] rsp_result_num;
   logic [RESULT_DEN_W-1:0] rsp_result_den;
   logic [ORDER_W-1:0] rsp_order;
   logic rsp_error;

   pending_op_type pending_ops[$];
   rational_result_type expected_results[$];
   fraction_pair_type driven_op;
   int unsigned active_mode = 0;
   int unsigned mismatch_count = 0;
   int unsigned arith_count = 0;
   int unsigned compare_count = 0;
   int unsigned flagged_count = 0;
   int unsigned quiet_cycles = 0;

   rational_arithmetic_unit #(
      .OPERAND_WIDTH(OPW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_first_num(req_first_num),
      .req_first_den(req_first_den),
      .req_second_num(req_second_num),
      .req_second_den(req_second_den),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_num(rsp_result_num),
      .rsp_result_den(rsp_result_den),
      .rsp_order(rsp_order),
      .rsp_error(rsp_error)
   );

   always #5 clock = ~clock;

   function automatic rational_result_type compute_rational(fraction_pair_type t);
      rational_result_type res;
      longint a, b, c, d, n, m, x, y, rem;
      res = '0;
      a = longint'(t.first_num);
      b = longint'(t.first_den);
      c = longint'(t.second_num);
      d = longint'(t.second_den);
      if (t.kind > KIND_CMP || b == 0 || d == 0) begin
         res.error = 1'b1;
         return res;
      end
      // move the sign of each operand onto its numerator
      if (b < 0) begin
         a = -a;
         b = -b;
      end
      if (d < 0) begin
         c = -c;
         d = -d;
      end
      case (t.kind)
         KIND_ADD: begin
            n = a * d + b * c;
            m = b * d;
         end
         KIND_SUB: begin
            n = a * d - b * c;
            m = b * d;
         end
         KIND_MUL: begin
            n = a * c;
            m = b * d;
         end
         KIND_DIV: begin
            if (c == 0) begin
               res.error = 1'b1;
               return res;
            end
            n = a * d;
            m = b * c;
         end
         default: begin
            if (a * d < c * b)
               res.order = ORDER_LESS;
            else if (a * d == c * b)
               res.order = ORDER_EQUAL;
            else
               res.order = ORDER_GREATER;
            return res;
         end
      endcase
      if (m < 0) begin
         n = -n;
         m = -m;
      end
      x = (n < 0) ? -n : n;
      y = m;
      while (y != 0) begin
         rem = x % y;
         x = y;
         y = rem;
      end
      res.num = RESULT_NUM_W'(n / x);
      res.den = RESULT_DEN_W'(m / x);
      return res;
   endfunction

   function automatic operand_type random_operand(int unsigned zero_pct);
      int unsigned sel;
      operand_type v;
      sel = $urandom_range(0, 99);
      if (sel < zero_pct)
         return '0;
      if (sel < zero_pct + 10) begin
         case ($urandom_range(0, 3))
            0: return OP_MIN;
            1: return OP_MAX;
            2: return operand_type'(1);
            default: return operand_type'(-1);
         endcase
      end
      if (sel < zero_pct + 45) begin
         v = operand_type'($urandom_range(1, 24));
         return ($urandom_range(0, 1) != 0) ? -v : v;
      end
      return operand_type'($urandom);
   endfunction

   function automatic fraction_pair_type make_op(logic [KIND_W-1:0] k, operand_type a,
                                                 operand_type b, operand_type c,
                                                 operand_type d);
      fraction_pair_type t;
      t.kind = k;
      t.first_num = a;
      t.first_den = b;
      t.second_num = c;
      t.second_den = d;
      return t;
   endfunction

   task automatic queue_op(fraction_pair_type op, int unsigned mode, bit drain);
      pending_op_type p;
      p.op = op;
      p.mode = mode;
      p.drain = drain;
      pending_ops.push_back(p);
   endtask

   // driver
   always @(posedge clock) begin
      pending_op_type nxt;
      bit take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(compute_rational(driven_op));
         if (!req_valid || !req_stall) begin
            take = 1'b0;
            if (pending_ops.size() != 0) begin
               nxt = pending_ops[0];
               take = !(nxt.drain && expected_results.size() != 0)
                      && ($urandom_range(0, 99) >= SEND_IDLE_PCT[nxt.mode]);
            end
            if (take) begin
               void'(pending_ops.pop_front());
               driven_op = nxt.op;
               active_mode = nxt.mode;
               req_kind <= nxt.op.kind;
               req_first_num <= nxt.op.first_num;
               req_first_den <= nxt.op.first_den;
               req_second_num <= nxt.op.second_num;
               req_second_den <= nxt.op.second_den;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rational_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("transaction with no expected result: num %0d den %0d order %0d error %0d",
                      rsp_result_num, rsp_result_den, rsp_order, rsp_error);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_num !== want.num) begin
                  $error("result_num expected %0d actual %0d", want.num, rsp_result_num);
                  mismatch_count++;
               end
               if (rsp_result_den !== want.den) begin
                  $error("result_den expected %0d actual %0d", want.den, rsp_result_den);
                  mismatch_count++;
               end
               if (rsp_order !== want.order) begin
                  $error("order expected %0d actual %0d", want.order, rsp_order);
                  mismatch_count++;
               end
               if (rsp_error !== want.error) begin
                  $error("error expected %0d actual %0d", want.error, rsp_error);
                  mismatch_count++;
               end
               if (want.error)
                  flagged_count++;
               else if (want.den == 0)
                  compare_count++;
               else
                  arith_count++;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < RECV_STALL_PCT[active_mode]);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      fraction_pair_type op;
      int unsigned sel;
      // directed cases
      queue_op(make_op(KIND_ADD, 1, 2, 1, 3), 0, 1'b0);
      queue_op(make_op(KIND_SUB, 1, 2, 1, 2), 0, 1'b0);
      queue_op(make_op(KIND_MUL, -3, 4, 4, -3), 0, 1'b0);
      queue_op(make_op(KIND_DIV, 2, 3, 4, 5), 0, 1'b0);
      queue_op(make_op(KIND_CMP, 1, 2, 1, 3), 0, 1'b0);
      queue_op(make_op(KIND_CMP, 1, 3, 2, 6), 0, 1'b0);
      queue_op(make_op(KIND_CMP, -1, 2, 1, -2), 0, 1'b0);
      queue_op(make_op(KIND_CMP, -1, 2, 1, 2), 0, 1'b0);
      queue_op(make_op(KIND_CMP, OP_MAX, OP_MAX, OP_MIN, OP_MIN), 0, 1'b0);
      queue_op(make_op(KIND_ADD, OP_MIN, 1, OP_MIN, 1), 0, 1'b0);
      queue_op(make_op(KIND_SUB, OP_MIN, -1, OP_MIN, 1), 0, 1'b0);
      queue_op(make_op(KIND_MUL, OP_MIN, -1, OP_MIN, -1), 0, 1'b0);
      queue_op(make_op(KIND_MUL, 1, OP_MIN, 1, OP_MIN), 0, 1'b0);
      queue_op(make_op(KIND_DIV, OP_MIN, 1, 1, OP_MIN), 0, 1'b0);
      queue_op(make_op(KIND_ADD, OP_MAX, OP_MIN, OP_MAX, operand_type'(OP_MAX - 1)), 0,
               1'b0);
      queue_op(make_op(KIND_ADD, 1, OP_MAX, 1, OP_MIN), 0, 1'b0);
      queue_op(make_op(KIND_MUL, 0, -7, 3, 5), 0, 1'b0);
      queue_op(make_op(KIND_ADD, 5, 0, 1, 2), 0, 1'b0);
      queue_op(make_op(KIND_CMP, 1, 2, 3, 0), 0, 1'b0);
      queue_op(make_op(KIND_DIV, 3, 4, 0, 5), 0, 1'b0);
      queue_op(make_op(KIND_DIV, 3, 4, 0, -5), 0, 1'b0);
      for (int k = int'(KIND_CMP) + 1; k <= int'(KIND_LAST_CODE); k++)
         queue_op(make_op(k[KIND_W-1:0], 1, 2, 1, 3), 0, 1'b0);
      // random phases: none, sender idle, receiver stall, both
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
               op.kind = KIND_W'(int'(KIND_LAST_CODE) -
                                 int'($urandom_range(0, int'(KIND_LAST_CODE - KIND_CMP) - 1)));
            else
               op.kind = KIND_W'($urandom_range(int'(KIND_ADD), int'(KIND_CMP)));
            op.first_num = random_operand(8);
            op.first_den = random_operand(3);
            if ($urandom_range(0, 99) < 8) begin
               op.second_num = op.first_num;
               op.second_den = op.first_den;
            end else begin
               op.second_num = random_operand(8);
               op.second_den = random_operand(3);
            end
            queue_op(op, p, (i == 0) || ($urandom_range(0, 99) == 0));
         end
      end
      wait (reset == 1'b0);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d transactions: %0d arithmetic, %0d compares, %0d flagged invalid",
               arith_count + compare_count + flagged_count, arith_count, compare_count,
               flagged_count);
      $display("stimulus ran through free-flowing, sender-idle, receiver-stall and mixed pacing");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

### filelist.f
rtl/rau_pkg.sv
rtl/rau_mul.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_tb.sv
